/* rtl/eeb_pkg.sv */
`default_nettype none

package eeb_pkg;

  localparam int unsigned WIDTH   = 32;
  localparam int unsigned COEFF_W = WIDTH + 1;
  localparam int unsigned CNT_W   = $clog2(WIDTH);
  localparam int unsigned UPC_W   = 3;

  typedef logic [UPC_W-1:0] upc_t;

  // Datapath operations selected by the control word
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DINIT,
    OP_DSTEP,
    OP_UPDATE,
    OP_FINISH
  } dp_op_e;

  // Jump conditions; a taken jump goes to the target, otherwise to the next step
  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_IN,
    JC_Q_ZERO,
    JC_CNT_NZ,
    JC_OUT_FULL
  } jump_cond_e;

  typedef struct packed {
    logic       in_ready;
    dp_op_e     op;
    jump_cond_e cond;
    upc_t       target;
  } ucode_t;

  typedef struct packed {
    logic in_fire;
    logic q_zero;
    logic cnt_nz;
    logic out_full;
  } dp_status_t;

  // Program addresses
  localparam upc_t UA_WAIT   = UPC_W'(0);
  localparam upc_t UA_CHECK  = UPC_W'(1);
  localparam upc_t UA_DINIT  = UPC_W'(2);
  localparam upc_t UA_DSTEP  = UPC_W'(3);
  localparam upc_t UA_UPDATE = UPC_W'(4);
  localparam upc_t UA_FINISH = UPC_W'(5);
  localparam upc_t UA_RETURN = UPC_W'(6);

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    w = '{in_ready: 1'b0, op: OP_NOP, cond: JC_ALWAYS, target: UA_WAIT};
    unique case (addr)
      UA_WAIT:   w = '{in_ready: 1'b1, op: OP_LOAD,   cond: JC_NO_IN,    target: UA_WAIT};
      UA_CHECK:  w = '{in_ready: 1'b0, op: OP_NOP,    cond: JC_Q_ZERO,   target: UA_FINISH};
      UA_DINIT:  w = '{in_ready: 1'b0, op: OP_DINIT,  cond: JC_NEVER,    target: UA_WAIT};
      UA_DSTEP:  w = '{in_ready: 1'b0, op: OP_DSTEP,  cond: JC_CNT_NZ,   target: UA_DSTEP};
      UA_UPDATE: w = '{in_ready: 1'b0, op: OP_UPDATE, cond: JC_ALWAYS,   target: UA_CHECK};
      UA_FINISH: w = '{in_ready: 1'b0, op: OP_FINISH, cond: JC_OUT_FULL, target: UA_FINISH};
      UA_RETURN: w = '{in_ready: 1'b0, op: OP_NOP,    cond: JC_ALWAYS,   target: UA_WAIT};
      default:   w = '{in_ready: 1'b0, op: OP_NOP,    cond: JC_ALWAYS,   target: UA_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/eeb_sequencer.sv */
`default_nettype none

module eeb_sequencer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire eeb_pkg::dp_status_t status_i,
  output eeb_pkg::ucode_t         ucode_o
);
  import eeb_pkg::*;

  upc_t upc_q, upc_d;
  logic take;

  assign ucode_o = ucode_rom(upc_q);

  always_comb begin
    unique case (ucode_o.cond)
      JC_NEVER:    take = 1'b0;
      JC_ALWAYS:   take = 1'b1;
      JC_NO_IN:    take = !status_i.in_fire;
      JC_Q_ZERO:   take = status_i.q_zero;
      JC_CNT_NZ:   take = status_i.cnt_nz;
      JC_OUT_FULL: take = status_i.out_full;
      default:     take = 1'b1;
    endcase
    upc_d = take ? ucode_o.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UA_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/eeb_datapath.sv */
`default_nettype none

module eeb_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire eeb_pkg::ucode_t                     ucode_i,
  output eeb_pkg::dp_status_t                      status_o,
  input  wire logic                                in_valid_i,
  input  wire logic [eeb_pkg::WIDTH-1:0]           value_a_i,
  input  wire logic [eeb_pkg::WIDTH-1:0]           value_b_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [eeb_pkg::WIDTH-1:0]                larger_value_o,
  output logic [eeb_pkg::WIDTH-1:0]                smaller_value_o,
  output logic                                     is_coprime_o,
  output logic                                     zero_operand_o,
  output logic signed [eeb_pkg::COEFF_W-1:0]       coeff_larger_o,
  output logic signed [eeb_pkg::COEFF_W-1:0]       coeff_smaller_o
);
  import eeb_pkg::*;

  logic [WIDTH-1:0]   big_q, small_q, p_q, q_q, rem_q, dv_q;
  logic [COEFF_W-1:0] s0_q, s1_q, t0_q, t1_q, accs_q, acct_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               zero_q;
  logic               out_valid_q;
  logic               in_fire, a_ge_b, ge, coprime;
  logic [WIDTH:0]     rem_sh, rem_sub;

  assign in_fire = in_valid_i && ucode_i.in_ready;
  assign a_ge_b  = value_a_i >= value_b_i;

  // one restoring-division bit: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, dv_q[WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, q_q};
  assign ge      = rem_sh >= {1'b0, q_q};
  assign coprime = !zero_q && (p_q == WIDTH'(1));

  assign status_o = '{in_fire:  in_fire,
                      q_zero:   (q_q == '0),
                      cnt_nz:   (cnt_q != '0),
                      out_full: out_valid_q};

  always_ff @(posedge clk_i) begin
    unique case (ucode_i.op)
      OP_LOAD: begin
        if (in_fire) begin
          big_q   <= a_ge_b ? value_a_i : value_b_i;
          small_q <= a_ge_b ? value_b_i : value_a_i;
          p_q     <= a_ge_b ? value_a_i : value_b_i;
          q_q     <= a_ge_b ? value_b_i : value_a_i;
          zero_q  <= (value_a_i == '0) || (value_b_i == '0);
          s0_q    <= COEFF_W'(1);
          t0_q    <= '0;
          s1_q    <= '0;
          t1_q    <= COEFF_W'(1);
        end
      end
      OP_DINIT: begin
        rem_q  <= '0;
        dv_q   <= p_q;
        accs_q <= '0;
        acct_q <= '0;
        cnt_q  <= CNT_W'(WIDTH - 1);
      end
      OP_DSTEP: begin
        rem_q  <= ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        dv_q   <= {dv_q[WIDTH-2:0], 1'b0};
        // accumulate quotient times coefficient, one quotient bit a step
        accs_q <= {accs_q[COEFF_W-2:0], 1'b0} + (ge ? s1_q : '0);
        acct_q <= {acct_q[COEFF_W-2:0], 1'b0} + (ge ? t1_q : '0);
        cnt_q  <= cnt_q - CNT_W'(1);
      end
      OP_UPDATE: begin
        p_q  <= q_q;
        q_q  <= rem_q;
        s0_q <= s1_q;
        s1_q <= s0_q - accs_q;
        t0_q <= t1_q;
        t1_q <= t0_q - acct_q;
      end
      OP_FINISH: begin
        if (!out_valid_q) begin
          larger_value_o  <= big_q;
          smaller_value_o <= small_q;
          is_coprime_o    <= coprime;
          zero_operand_o  <= zero_q;
          coeff_larger_o  <= coprime ? $signed(s0_q) : '0;
          coeff_smaller_o <= coprime ? $signed(t0_q) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ucode_i.op == OP_FINISH && !out_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/extended_euclid_bezout.sv */
// Extended Euclid with Bezout coefficients.
// Input channel (in_valid_i / in_ready_o) carries one beat of two unsigned
// operands. The block orders them, runs Euclid's division steps and returns
// one result beat on the output channel (out_valid_o / out_ready_i): larger
// and smaller operand, a coprime flag, a zero-operand flag and, when coprime,
// coefficients x, y with 1 = x*larger + y*smaller (33-bit two's complement).
// One item is worked at a time; in_ready_o is high only while the sequencer
// waits for a new beat. An item runs up to 45 division steps for 32-bit
// operands. Each division step runs the check, divider setup, one divider
// step per quotient bit and the update; the single shared shift-subtract
// divider retires one quotient bit per cycle, and the same bit folds the
// quotient into both coefficient accumulators.
// The result sits in an output register; once it is loaded the input reopens
// by way of the return step, while the receiver may still stall. A new result
// waits in the sequencer until the output register frees up.
// Reset (rst_ni low, asynchronous) returns the sequencer to its wait step and
// empties the output register.
`default_nettype none

module extended_euclid_bezout (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [eeb_pkg::WIDTH-1:0]           value_a_i,
  input  wire logic [eeb_pkg::WIDTH-1:0]           value_b_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [eeb_pkg::WIDTH-1:0]                larger_value_o,
  output logic [eeb_pkg::WIDTH-1:0]                smaller_value_o,
  output logic                                     is_coprime_o,
  output logic                                     zero_operand_o,
  output logic signed [eeb_pkg::COEFF_W-1:0]       coeff_larger_o,
  output logic signed [eeb_pkg::COEFF_W-1:0]       coeff_smaller_o
);
  import eeb_pkg::*;

  ucode_t     ucode;
  dp_status_t status;

  // control word per step; jumps on the datapath status flags
  eeb_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ucode_o  (ucode)
  );

  // operand, divider, coefficient and output registers
  eeb_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ucode_i         (ucode),
    .status_o        (status),
    .in_valid_i      (in_valid_i),
    .value_a_i       (value_a_i),
    .value_b_i       (value_b_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .larger_value_o  (larger_value_o),
    .smaller_value_o (smaller_value_o),
    .is_coprime_o    (is_coprime_o),
    .zero_operand_o  (zero_operand_o),
    .coeff_larger_o  (coeff_larger_o),
    .coeff_smaller_o (coeff_smaller_o)
  );

  assign in_ready_o = ucode.in_ready;

`ifndef NO_ASSERTIONS
  // one item at a time: an accepted beat closes the input until the work is done
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> larger_value_o >= smaller_value_o)
    else $error("operands not ordered");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_coprime_o && zero_operand_o))
    else $error("coprime reported with zero operand");

  a_zero_coeff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_coprime_o |-> coeff_larger_o == '0 && coeff_smaller_o == '0)
    else $error("coefficients nonzero without coprime result");
`endif

endmodule

`default_nettype wire

/* bench/extended_euclid_bezout_tb.sv */
`default_nettype none

module extended_euclid_bezout_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eeb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned QUIET_FROM   = 150;  // first beat of the stretch without idling
  localparam int unsigned QUIET_TO     = 250;  // first beat after it
  localparam int unsigned HOLD_AFTER   = 40;   // input beats before the long receiver hold
  localparam int unsigned HOLD_CYCLES  = 6000;
  localparam int unsigned DRAIN_CYCLES = 100;

  // One result beat, in port order
  typedef struct packed {
    logic [WIDTH-1:0]   larger;
    logic [WIDTH-1:0]   smaller;
    logic               is_coprime;
    logic               zero_operand;
    logic [COEFF_W-1:0] coeff_larger;
    logic [COEFF_W-1:0] coeff_smaller;
  } bezout_result_t;

  // Directed row: operands, and a typed-in result where one is given
  typedef struct packed {
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic             typed;
    bezout_result_t   want;
  } operand_row_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [WIDTH-1:0]   value_a_i       = '0;
  logic [WIDTH-1:0]   value_b_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [WIDTH-1:0]   larger_value_o;
  logic [WIDTH-1:0]   smaller_value_o;
  logic               is_coprime_o;
  logic               zero_operand_o;
  logic signed [COEFF_W-1:0] coeff_larger_o;
  logic signed [COEFF_W-1:0] coeff_smaller_o;

  // Results owed by the block, oldest first
  bezout_result_t pending_results[$];
  bezout_result_t result_want;
  operand_row_t   directed_rows[20];

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  logic        hold_off     = 1'b0;

  always #4 clk_i = ~clk_i;

  extended_euclid_bezout dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_a_i      (value_a_i),
    .value_b_i      (value_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .larger_value_o (larger_value_o),
    .smaller_value_o(smaller_value_o),
    .is_coprime_o   (is_coprime_o),
    .zero_operand_o (zero_operand_o),
    .coeff_larger_o (coeff_larger_o),
    .coeff_smaller_o(coeff_smaller_o)
  );

  // Order the operands, run the division chain, then back-substitute the
  // quotients from the last nonzero remainder upward. Coefficient arithmetic
  // wraps at 64 bits and is cut to the coefficient width at the end.
  function automatic bezout_result_t solve_bezout(input logic [WIDTH-1:0] a,
                                                  input logic [WIDTH-1:0] b);
    logic [63:0]    big, sml, p, q, r, cs, csub, nsub;
    logic [63:0]    quots[$];
    int             i;
    bezout_result_t res;
    big = (a >= b) ? 64'(a) : 64'(b);
    sml = (a >= b) ? 64'(b) : 64'(a);
    res = '0;
    res.larger       = big[WIDTH-1:0];
    res.smaller      = sml[WIDTH-1:0];
    res.zero_operand = (sml == 64'd0);
    if (!res.zero_operand) begin
      if (sml == 64'd1) begin
        // a smaller operand of one is always coprime: 0*larger + 1*1
        res.is_coprime    = 1'b1;
        res.coeff_smaller = COEFF_W'(1);
      end else begin
        p = big;
        q = sml;
        while (q != 64'd0) begin
          r = p % q;
          quots = {quots, p / q};
          p = q;
          q = r;
        end
        // p holds the gcd now
        if (p == 64'd1 && quots.size() >= 2) begin
          cs   = 64'd1;
          csub = 64'd0 - quots[quots.size() - 2];
          i    = quots.size() - 2;
          while (i > 0) begin
            i--;
            nsub = cs - csub * quots[i];
            cs   = csub;
            csub = nsub;
          end
          res.is_coprime    = 1'b1;
          res.coeff_larger  = COEFF_W'(cs);
          res.coeff_smaller = COEFF_W'(csub);
        end
      end
    end
    return res;
  endfunction

  // Consecutive Fibonacci numbers make the longest division chains
  function automatic logic [63:0] fibonacci(input int unsigned k);
    logic [63:0] f0, f1, t;
    f0 = 64'd0;
    f1 = 64'd1;
    repeat (k) begin
      t  = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    return f0;
  endfunction

  // Draw one random operand pair
  task automatic pick_operands(output logic [WIDTH-1:0] a, output logic [WIDTH-1:0] b);
    int unsigned kind, k, g;
    logic [63:0] t;
    kind = $urandom_range(99);
    if (kind < 30) begin
      a = $urandom;
      b = $urandom;
    end else if (kind < 45) begin
      // neighbors are coprime, with a short chain (b wraps to zero when a is all ones)
      a = $urandom;
      b = a + 1;
    end else if (kind < 55) begin
      k = $urandom_range(3, 46);
      a = WIDTH'(fibonacci(k + 1));
      b = WIDTH'(fibonacci(k));
    end else if (kind < 67) begin
      // small values hit zero, one and equal operands often
      a = $urandom_range(64);
      b = $urandom_range(64);
    end else if (kind < 75) begin
      a = $urandom_range(1);
      b = $urandom;
      if ($urandom_range(3) == 0) begin
        b = a;
      end
    end else if (kind < 85) begin
      // shared factor: never coprime
      g = $urandom_range(2, 1000);
      t = 64'(g) * 64'($urandom_range(1, 4000000));
      a = WIDTH'(t);
      t = 64'(g) * 64'($urandom_range(1, 4000000));
      b = WIDTH'(t);
    end else begin
      a = $urandom >> $urandom_range(31);
      b = $urandom >> $urandom_range(31);
    end
    if ($urandom_range(1) == 1) begin
      {a, b} = {b, a};
    end
  endtask

  // Offer one input beat; hold valid and payload until the block takes it
  task automatic send_operands(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b,
                               input bezout_result_t want, input int unsigned idx);
    int unsigned gap;
    gap = 0;
    if (idx < QUIET_FROM || idx >= QUIET_TO) begin
      while ($urandom_range(99) < 7) begin
        gap++;
      end
      // now and then drop valid for a long while, so beats arrive in odd phases
      if ($urandom_range(99) < 3) begin
        gap += $urandom_range(1, 400);
      end
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_a_i  <= a;
    value_b_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    pending_results = {pending_results, want};
    items_sent <= items_sent + 1;
  endtask

  // Receiver: stall at random, except in the quiet stretch and during the hold
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 7);
    end
  end

  // Hold the output channel off long enough that a finished result backs up
  // in the block and input beats stall behind it
  initial begin
    while (items_sent < HOLD_AFTER) begin
      @(posedge clk_i);
    end
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Check every result beat against the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing owed: larger %h smaller %h",
               larger_value_o, smaller_value_o);
        fail_count++;
      end else begin
        result_want = pending_results.pop_front();
        if (larger_value_o !== result_want.larger) begin
          $error("larger_value: expected %h, got %h", result_want.larger, larger_value_o);
          fail_count++;
        end
        if (smaller_value_o !== result_want.smaller) begin
          $error("smaller_value: expected %h, got %h", result_want.smaller, smaller_value_o);
          fail_count++;
        end
        if (is_coprime_o !== result_want.is_coprime) begin
          $error("is_coprime: expected %b, got %b", result_want.is_coprime, is_coprime_o);
          fail_count++;
        end
        if (zero_operand_o !== result_want.zero_operand) begin
          $error("zero_operand: expected %b, got %b",
                 result_want.zero_operand, zero_operand_o);
          fail_count++;
        end
        if (coeff_larger_o !== result_want.coeff_larger) begin
          $error("coeff_larger: expected %h, got %h",
                 result_want.coeff_larger, coeff_larger_o);
          fail_count++;
        end
        if (coeff_smaller_o !== result_want.coeff_smaller) begin
          $error("coeff_smaller: expected %h, got %h",
                 result_want.coeff_smaller, coeff_smaller_o);
          fail_count++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  initial begin
    logic [WIDTH-1:0] a, b;
    bezout_result_t   want;
    int unsigned      idx;

    // Extremes, zero operands, a smaller operand of one and equal operands
    // carry typed results; the rest go through the predictor.
    directed_rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 33'h0, 33'h0}},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 33'h0, 33'h0}},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 33'h0, 33'h0}},
      '{32'h0000_3039, 32'h0000_0000, 1'b1,
        '{32'h0000_3039, 32'h0000_0000, 1'b0, 1'b1, 33'h0, 33'h0}},
      '{32'h0000_0001, 32'h0000_0001, 1'b1,
        '{32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, 33'h0, 33'h1}},
      '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 33'h0, 33'h1}},
      '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1,
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 33'h0, 33'h1}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 33'h0, 33'h0}},
      '{32'h0000_0002, 32'h0000_0002, 1'b1,
        '{32'h0000_0002, 32'h0000_0002, 1'b0, 1'b0, 33'h0, 33'h0}},
      '{32'h0000_0007, 32'h0000_0007, 1'b1,
        '{32'h0000_0007, 32'h0000_0007, 1'b0, 1'b0, 33'h0, 33'h0}},
      '{32'h0000_000C, 32'h0000_0012, 1'b0, '0},
      '{32'h0000_0003, 32'h0000_0002, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
      '{32'hB11924E1, 32'h6D73E55F, 1'b0, '0},
      '{32'h6D73E55F, 32'hB11924E1, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
      '{32'hFFFF_FFFB, 32'h0001_0000, 1'b0, '0},
      '{32'h0001_0001, 32'h0001_0000, 1'b0, '0},
      '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0}
    };

    // Hold reset low at the start, then release it at a clock edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    idx = 0;
    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].want
                                    : solve_bezout(directed_rows[i].a, directed_rows[i].b);
      send_operands(directed_rows[i].a, directed_rows[i].b, want, idx);
      idx++;
    end

    repeat (RANDOM_ITEMS) begin
      pick_operands(a, b);
      send_operands(a, b, solve_bezout(a, b), idx);
      idx++;
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every owed result, then let any stray beat show up
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("extended_euclid_bezout_tb: PASS");
    end else begin
      $display("extended_euclid_bezout_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #25_000_000;
    $display("extended_euclid_bezout_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
